@@ rtl/c2s_pkg.sv @@
`timescale 1ns / 1ps
// c2s_pkg: widths, angle constants and the arctangent table for the
// cartesian-to-spherical pipeline. No dependencies.
package c2s_pkg;

    localparam int COORD_W    = 32;   // input coordinate width, Q16.16
    localparam int GUARD      = 8;    // guard fraction bits
    localparam int ZW         = COORD_W + GUARD;
    localparam int DW         = 44;   // CORDIC datapath width
    localparam int AW         = 33;   // angle accumulator width, Q.28
    localparam int MAX_STAGES = 28;
    localparam int RANGE_W    = 32;
    localparam int EL_W       = 18;
    localparam int AZ_W       = 20;
    localparam int ANG_SHIFT  = 12;   // Q.28 -> Q.16

    localparam logic [31:0]          GAIN_INV    = 32'h9B74EDA8;
    localparam logic signed [AW-1:0] PI_Q28      = 33'sd843314857;
    localparam logic signed [AW-1:0] HALF_PI_Q28 = 33'sd421657428;
    localparam logic signed [AW-1:0] ANG_RND     = 33'sd2048;

    localparam logic [27:0] ATAN_Q28 [MAX_STAGES] = '{
        28'd210828714, 28'd124459457, 28'd65760959, 28'd33381290, 28'd16755422,
        28'd8385879,   28'd4193963,   28'd2097109,  28'd1048571,  28'd524287,
        28'd262144,    28'd131072,    28'd65536,    28'd32768,    28'd16384,
        28'd8192,      28'd4096,      28'd2048,     28'd1024,     28'd512,
        28'd256,       28'd128,       28'd64,       28'd32,       28'd16,
        28'd8,         28'd4,         28'd2
    };

endpackage

@@ rtl/cartesian_to_spherical.sv @@
`timescale 1ns / 1ps
// cartesian_to_spherical: pipelined 3D point to range/elevation/azimuth converter.
// Depends on c2s_pkg, c2s_vector, c2s_gain.
//
//  channel  | handshake       | fields
//  ---------+-----------------+------------------------------------------------
//  request  | start, busy     | i_coord_x, i_coord_y, i_coord_z (signed Q16.16)
//  result   | o_valid strobe  | o_radial_range, o_elevation, o_azimuth_shifted
//
// One request per cycle; busy is always low. With N = min(CORDIC_STAGES, 28),
// the pipeline is: input register, N stages of the (x,y) pass, gain
// correction, a join register, N stages of the (r,z) pass, gain correction
// and the output register. Synchronous reset clears all valid bits.
// No backpressure: each result is shown for one cycle only.
module cartesian_to_spherical #(
    parameter int CORDIC_STAGES = 18
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [c2s_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [c2s_pkg::COORD_W-1:0]  i_coord_y,
    input  logic signed [c2s_pkg::COORD_W-1:0]  i_coord_z,
    output logic                                o_valid,
    output logic [c2s_pkg::RANGE_W-1:0]         o_radial_range,
    output logic signed [c2s_pkg::EL_W-1:0]     o_elevation,
    output logic signed [c2s_pkg::AZ_W-1:0]     o_azimuth_shifted
);
    localparam int DW    = c2s_pkg::DW;
    localparam int AW    = c2s_pkg::AW;
    localparam int ZW    = c2s_pkg::ZW;
    localparam int CW    = c2s_pkg::COORD_W;
    localparam int GB    = c2s_pkg::GUARD;
    localparam int SH    = c2s_pkg::ANG_SHIFT;
    localparam int NSTG  = (CORDIC_STAGES > c2s_pkg::MAX_STAGES) ?
                           c2s_pkg::MAX_STAGES : CORDIC_STAGES;
    localparam int SW1   = ZW + 1;           // {nz, z}
    localparam int SWG1  = AW + SW1;         // {az, nz, z}
    localparam int SW2   = AW + 3 + ZW;      // {az, rz, zneg, znz, |z|}
    localparam int SWG2  = AW + SW2;         // {el, ...}
    localparam int RW    = DW - GB + 1;

    // input register
    logic signed [DW-1:0] xs, ys;
    logic signed [DW-1:0] n_x0, n_y0;
    logic signed [AW-1:0] n_az0;
    logic                 r_v0;
    logic signed [DW-1:0] r_x0, r_y0;
    logic signed [AW-1:0] r_az0;
    logic signed [ZW-1:0] r_z0;
    logic                 r_nz0;

    assign busy = 1'b0;
    assign xs = {{(DW-ZW){i_coord_x[CW-1]}}, i_coord_x, {GB{1'b0}}};
    assign ys = {{(DW-ZW){i_coord_y[CW-1]}}, i_coord_y, {GB{1'b0}}};

    always_comb begin
        if (i_coord_x[CW-1]) begin
            n_x0  = -xs;
            n_y0  = -ys;
            n_az0 = i_coord_y[CW-1] ? -c2s_pkg::PI_Q28 : c2s_pkg::PI_Q28;
        end else begin
            n_x0  = xs;
            n_y0  = ys;
            n_az0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x0  <= n_x0;
        r_y0  <= n_y0;
        r_az0 <= n_az0;
        r_z0  <= {i_coord_z, {GB{1'b0}}};
        r_nz0 <= (|i_coord_x) | (|i_coord_y);
    end

    // horizontal pass
    logic                 v1;
    logic signed [DW-1:0] x1;
    logic signed [AW-1:0] az1;
    logic [SW1-1:0]       side1;

    c2s_vector #(.NSTG(NSTG), .SW(SW1)) u_vec_xy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v0),
        .i_x     (r_x0),
        .i_y     (r_y0),
        .i_ang   (r_az0),
        .i_side  ({r_nz0, r_z0}),
        .o_valid (v1),
        .o_x     (x1),
        .o_ang   (az1),
        .o_side  (side1)
    );

    logic              vg1;
    logic [DW-1:0]     rxy;
    logic [SWG1-1:0]   sideg1;

    c2s_gain #(.SW(SWG1)) u_gain_xy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v1),
        .i_a     (x1),
        .i_side  ({az1, side1}),
        .o_valid (vg1),
        .o_p     (rxy),
        .o_side  (sideg1)
    );

    // join register
    logic signed [AW-1:0] g1_az;
    logic                 g1_nz;
    logic signed [ZW-1:0] g1_z;
    logic                 r_vm;
    logic signed [DW-1:0] r_xm, r_ym;
    logic signed [AW-1:0] r_azm;
    logic                 r_rzm, r_znegm, r_znzm;
    logic [ZW-1:0]        r_absz;

    assign {g1_az, g1_nz, g1_z} = sideg1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else begin
            r_vm <= vg1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xm    <= rxy;
        r_ym    <= {{(DW-ZW){g1_z[ZW-1]}}, g1_z};
        r_azm   <= g1_nz ? g1_az : '0;
        r_rzm   <= (rxy == '0);
        r_znegm <= g1_z[ZW-1];
        r_znzm  <= |g1_z;
        r_absz  <= g1_z[ZW-1] ? ZW'(-g1_z) : ZW'(g1_z);
    end

    // vertical pass
    logic                 v2;
    logic signed [DW-1:0] x2;
    logic signed [AW-1:0] el2;
    logic [SW2-1:0]       side2;

    c2s_vector #(.NSTG(NSTG), .SW(SW2)) u_vec_rz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vm),
        .i_x     (r_xm),
        .i_y     (r_ym),
        .i_ang   ('0),
        .i_side  ({r_azm, r_rzm, r_znegm, r_znzm, r_absz}),
        .o_valid (v2),
        .o_x     (x2),
        .o_ang   (el2),
        .o_side  (side2)
    );

    logic              vg2;
    logic [DW-1:0]     rng;
    logic [SWG2-1:0]   sideg2;

    c2s_gain #(.SW(SWG2)) u_gain_rz (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v2),
        .i_a     (x2),
        .i_side  ({el2, side2}),
        .o_valid (vg2),
        .o_p     (rng),
        .o_side  (sideg2)
    );

    // output stage
    logic signed [AW-1:0] g2_el, g2_az, el_sel, el_rnd, az_rnd;
    logic                 g2_rz, g2_zneg, g2_znz;
    logic [ZW-1:0]        g2_absz;
    logic [DW-1:0]        rng_sel;
    logic [DW:0]          rng_rnd;
    logic [RW-1:0]        rng_q;
    logic [c2s_pkg::RANGE_W-1:0] n_range;
    logic                 r_vo;
    logic [c2s_pkg::RANGE_W-1:0]     r_range;
    logic signed [c2s_pkg::EL_W-1:0] r_el;
    logic signed [c2s_pkg::AZ_W-1:0] r_az;

    assign {g2_el, g2_az, g2_rz, g2_zneg, g2_znz, g2_absz} = sideg2;

    always_comb begin
        if (g2_rz) begin
            rng_sel = DW'(g2_absz);
            if (!g2_znz) begin
                el_sel = '0;
            end else if (g2_zneg) begin
                el_sel = -c2s_pkg::HALF_PI_Q28;
            end else begin
                el_sel = c2s_pkg::HALF_PI_Q28;
            end
        end else begin
            rng_sel = rng;
            el_sel  = g2_el;
        end
    end

    assign rng_rnd = {1'b0, rng_sel} + (DW+1)'(1 << (GB-1));
    assign rng_q   = rng_rnd[DW:GB];
    assign n_range = (|rng_q[RW-1:c2s_pkg::RANGE_W]) ? '1 : rng_q[c2s_pkg::RANGE_W-1:0];
    assign el_rnd  = el_sel + c2s_pkg::ANG_RND;
    assign az_rnd  = g2_az + c2s_pkg::HALF_PI_Q28 + c2s_pkg::ANG_RND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else begin
            r_vo <= vg2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_range <= n_range;
        r_el    <= el_rnd[SH+c2s_pkg::EL_W-1:SH];
        r_az    <= az_rnd[SH+c2s_pkg::AZ_W-1:SH];
    end

    assign o_valid           = r_vo;
    assign o_radial_range    = r_range;
    assign o_elevation       = r_el;
    assign o_azimuth_shifted = r_az;

endmodule

@@ rtl/c2s_cordic_stage.sv @@
`timescale 1ns / 1ps
// c2s_cordic_stage: one registered CORDIC vectoring micro-rotation.
// Depends on c2s_pkg for widths and the arctangent table.
module c2s_cordic_stage #(
    parameter int SHIFT = 0,
    parameter int SW    = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic signed [c2s_pkg::DW-1:0]     i_x,
    input  logic signed [c2s_pkg::DW-1:0]     i_y,
    input  logic signed [c2s_pkg::AW-1:0]     i_ang,
    input  logic [SW-1:0]                     i_side,
    output logic                              o_valid,
    output logic signed [c2s_pkg::DW-1:0]     o_x,
    output logic signed [c2s_pkg::DW-1:0]     o_y,
    output logic signed [c2s_pkg::AW-1:0]     o_ang,
    output logic [SW-1:0]                     o_side
);
    localparam int DW = c2s_pkg::DW;
    localparam int AW = c2s_pkg::AW;
    localparam logic signed [AW-1:0] STEP_ANG =
        signed'({{(AW-28){1'b0}}, c2s_pkg::ATAN_Q28[SHIFT]});

    logic signed [DW-1:0] dx, dy;
    logic signed [DW-1:0] n_x, n_y;
    logic signed [AW-1:0] n_ang;
    logic                 r_valid;
    logic signed [DW-1:0] r_x, r_y;
    logic signed [AW-1:0] r_ang;
    logic [SW-1:0]        r_side;

    assign dx = i_y >>> SHIFT;
    assign dy = i_x >>> SHIFT;

    always_comb begin
        if (!i_y[DW-1]) begin
            n_x   = i_x + dx;
            n_y   = i_y - dy;
            n_ang = i_ang + STEP_ANG;
        end else begin
            n_x   = i_x - dx;
            n_y   = i_y + dy;
            n_ang = i_ang - STEP_ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_ang  <= n_ang;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_ang   = r_ang;
    assign o_side  = r_side;

endmodule

@@ rtl/c2s_vector.sv @@
`timescale 1ns / 1ps
// c2s_vector: a chain of NSTG CORDIC vectoring stages, one register each.
// Depends on c2s_pkg and c2s_cordic_stage.
module c2s_vector #(
    parameter int NSTG = 18,
    parameter int SW   = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic signed [c2s_pkg::DW-1:0]     i_x,
    input  logic signed [c2s_pkg::DW-1:0]     i_y,
    input  logic signed [c2s_pkg::AW-1:0]     i_ang,
    input  logic [SW-1:0]                     i_side,
    output logic                              o_valid,
    output logic signed [c2s_pkg::DW-1:0]     o_x,
    output logic signed [c2s_pkg::AW-1:0]     o_ang,
    output logic [SW-1:0]                     o_side
);
    localparam int DW = c2s_pkg::DW;
    localparam int AW = c2s_pkg::AW;

    logic                 v_c    [NSTG+1];
    logic signed [DW-1:0] x_c    [NSTG+1];
    logic signed [DW-1:0] y_c    [NSTG+1];
    logic signed [AW-1:0] ang_c  [NSTG+1];
    logic [SW-1:0]        side_c [NSTG+1];

    assign v_c[0]    = i_valid;
    assign x_c[0]    = i_x;
    assign y_c[0]    = i_y;
    assign ang_c[0]  = i_ang;
    assign side_c[0] = i_side;

    for (genvar g = 0; g < NSTG; g++) begin : g_stage
        c2s_cordic_stage #(
            .SHIFT (g),
            .SW    (SW)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v_c[g]),
            .i_x     (x_c[g]),
            .i_y     (y_c[g]),
            .i_ang   (ang_c[g]),
            .i_side  (side_c[g]),
            .o_valid (v_c[g+1]),
            .o_x     (x_c[g+1]),
            .o_y     (y_c[g+1]),
            .o_ang   (ang_c[g+1]),
            .o_side  (side_c[g+1])
        );
    end

    assign o_valid = v_c[NSTG];
    assign o_x     = x_c[NSTG];
    assign o_ang   = ang_c[NSTG];
    assign o_side  = side_c[NSTG];

endmodule

@@ rtl/c2s_gain.sv @@
`timescale 1ns / 1ps
// c2s_gain: two-stage CORDIC gain correction, round(a * GAIN_INV / 2^32).
// Depends on c2s_pkg.
module c2s_gain #(
    parameter int SW = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [c2s_pkg::DW-1:0]      i_a,
    input  logic [SW-1:0]               i_side,
    output logic                        o_valid,
    output logic [c2s_pkg::DW-1:0]      o_p,
    output logic [SW-1:0]               o_side
);
    localparam int DW = c2s_pkg::DW;

    logic              r_valid_a, r_valid_b;
    logic [63:0]       r_plo;
    logic [DW-1:0]     r_phi;
    logic [SW-1:0]     r_side_a, r_side_b;
    logic [DW-1:0]     r_p;
    logic [64:0]       lo_rnd;
    logic [DW-1:0]     n_p;

    assign lo_rnd = {1'b0, r_plo} + 65'h0_8000_0000;
    assign n_p    = r_phi + DW'(lo_rnd[64:32]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_plo    <= 64'(i_a[31:0]) * 64'(c2s_pkg::GAIN_INV);
        r_phi    <= DW'(i_a[DW-1:32]) * DW'(c2s_pkg::GAIN_INV);
        r_side_a <= i_side;
        r_p      <= n_p;
        r_side_b <= r_side_a;
    end

    assign o_valid = r_valid_b;
    assign o_p     = r_p;
    assign o_side  = r_side_b;

endmodule

@@ tb/sv/cartesian_to_spherical_tb.sv @@
`timescale 1ns / 1ps
// cartesian_to_spherical_tb: self-checking bench for the 3D point to spherical converter.
// Uses c2s_pkg and cartesian_to_spherical.
// It predicts every result from its own fixed-point CORDIC model and checks results in order.
module cartesian_to_spherical_tb;

    localparam int    STAGES    = 18;
    localparam int    PASSES    = (STAGES > 28) ? 28 : STAGES;
    localparam int    LATENCY   = 2 * PASSES + 7;
    localparam int    LIMIT     = 200000;
    localparam int    MAX_SHOWN = 10;
    localparam int    RING_DEPTH = 256;

    localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] C_MIN = 32'sh8000_0000;

    localparam longint          PI_ANG      = 64'sd843314857;
    localparam longint          HALF_PI_ANG = 64'sd421657428;
    localparam longint unsigned INV_GAIN    = 64'd2608131496;

    localparam longint ARCTAN [28] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
        2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2
    };

    typedef struct {
        logic [c2s_pkg::RANGE_W-1:0]        rng;
        logic signed [c2s_pkg::EL_W-1:0]    elev;
        logic signed [c2s_pkg::AZ_W-1:0]    azim;
    } sph_t;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                start;
    logic                                busy;
    logic signed [c2s_pkg::COORD_W-1:0]  i_coord_x;
    logic signed [c2s_pkg::COORD_W-1:0]  i_coord_y;
    logic signed [c2s_pkg::COORD_W-1:0]  i_coord_z;
    logic                                o_valid;
    logic [c2s_pkg::RANGE_W-1:0]         o_radial_range;
    logic signed [c2s_pkg::EL_W-1:0]     o_elevation;
    logic signed [c2s_pkg::AZ_W-1:0]     o_azimuth_shifted;

    // expected results, written at accept and read back in order
    sph_t expected_ring [RING_DEPTH];
    int   ring_wr;
    int   ring_rd;
    int   mismatch_cnt;
    int   idle_pct;
    int   cycle_cnt;

    cartesian_to_spherical #(
        .CORDIC_STAGES(STAGES)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_coord_x         (i_coord_x),
        .i_coord_y         (i_coord_y),
        .i_coord_z         (i_coord_z),
        .o_valid           (o_valid),
        .o_radial_range    (o_radial_range),
        .o_elevation       (o_elevation),
        .o_azimuth_shifted (o_azimuth_shifted)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // vectoring: rotate (x, y) onto the x axis, accumulating the angle in Q.28
    function automatic void rotate_to_axis(inout longint x, inout longint y,
                                           inout longint ang);
        longint dx;
        longint dy;
        for (int i = 0; i < PASSES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx;
                y -= dy;
                ang += ARCTAN[i];
            end else begin
                x -= dx;
                y += dy;
                ang -= ARCTAN[i];
            end
        end
    endfunction

    function automatic longint unsigned undo_gain(longint unsigned a);
        longint unsigned hi;
        longint unsigned lo;
        hi = a >> 32;
        lo = a & 64'hFFFF_FFFF;
        return hi * INV_GAIN + ((lo * INV_GAIN + 64'h8000_0000) >> 32);
    endfunction

    function automatic sph_t predict_spherical(logic signed [31:0] cx,
                                               logic signed [31:0] cy,
                                               logic signed [31:0] cz);
        longint          x;
        longint          y;
        longint          z;
        longint          az;
        longint          el;
        longint          x2;
        longint          y2;
        longint          el16;
        longint          az16;
        longint unsigned rxy;
        longint unsigned reach;
        sph_t            r;
        x   = longint'(cx) * 256;
        y   = longint'(cy) * 256;
        z   = longint'(cz) * 256;
        az  = 0;
        el  = 0;
        rxy = 0;
        if (x != 0 || y != 0) begin
            if (x < 0) begin
                az = (y >= 0) ? PI_ANG : -PI_ANG;
                x  = -x;
                y  = -y;
            end
            rotate_to_axis(x, y, az);
            rxy = undo_gain(longint'(x));
        end
        if (rxy == 0) begin
            el    = (z > 0) ? HALF_PI_ANG : ((z < 0) ? -HALF_PI_ANG : 0);
            reach = (z < 0) ? -z : z;
        end else begin
            x2 = rxy;
            y2 = z;
            rotate_to_axis(x2, y2, el);
            reach = undo_gain(longint'(x2));
        end
        reach = (reach + 128) >> 8;
        if (reach > 64'hFFFF_FFFF)
            reach = 64'hFFFF_FFFF;
        el16   = (el + 2048) >>> 12;
        az16   = (az + HALF_PI_ANG + 2048) >>> 12;
        r.rng  = reach[c2s_pkg::RANGE_W-1:0];
        r.elev = el16[c2s_pkg::EL_W-1:0];
        r.azim = az16[c2s_pkg::AZ_W-1:0];
        return r;
    endfunction

    function automatic logic signed [31:0] random_coord();
        logic signed [31:0] v;
        v = $urandom;
        case ($urandom_range(9))
            0: v = '0;
            1: v = $urandom_range(1) ? C_MAX : C_MIN;
            2, 3, 4: v = v >>> $urandom_range(31);
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_point(input logic signed [31:0] px,
                              input logic signed [31:0] py,
                              input logic signed [31:0] pz);
        while ($urandom_range(99) < idle_pct) begin
            start     <= 1'b0;
            i_coord_x <= $urandom;
            i_coord_y <= $urandom;
            i_coord_z <= $urandom;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_coord_x <= px;
        i_coord_y <= py;
        i_coord_z <= pz;
        do @(posedge i_clk); while (busy);
        expected_ring[ring_wr % RING_DEPTH] = predict_spherical(px, py, pz);
        ring_wr++;
    endtask

    task automatic drain_backlog();
        start <= 1'b0;
        while (ring_wr != ring_rd)
            @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input longint want, input longint got);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_SHOWN)
            $display("mismatch %s: expected %0d, got %0d", what, want, got);
    endtask

    // result checker: outputs sampled at the edge that accepts them
    always @(posedge i_clk) begin
        sph_t want;
        if (i_rst_n && o_valid) begin
            if (ring_wr == ring_rd) begin
                note_mismatch("unexpected result, range", 0, o_radial_range);
            end else begin
                want = expected_ring[ring_rd % RING_DEPTH];
                ring_rd++;
                if (o_radial_range !== want.rng)
                    note_mismatch("range", want.rng, o_radial_range);
                if (o_elevation !== want.elev)
                    note_mismatch("elevation", want.elev, o_elevation);
                if (o_azimuth_shifted !== want.azim)
                    note_mismatch("azimuth", want.azim, o_azimuth_shifted);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT) begin
            $display("cartesian_to_spherical_tb: errors");
            $finish;
        end
    end

    task automatic test_origin_and_axes();
        send_point(0, 0, 0);
        send_point(0, 0, 1);
        send_point(0, 0, -1);
        send_point(0, 0, C_MAX);
        send_point(0, 0, C_MIN);
        send_point(1, 0, 0);
        send_point(0, 1, 0);
        send_point(0, -1, 0);
        send_point(C_MAX, 0, 0);
        send_point(0, C_MIN, 0);
        send_point(0, C_MAX, 0);
    endtask

    task automatic test_negative_x();
        send_point(-1, 0, 0);
        send_point(C_MIN, 0, 0);
        send_point(-5, 7, 0);
        send_point(-5, -7, 3);
        send_point(-32'sd65536, 0, 32'sd65536);
    endtask

    task automatic test_extremes();
        send_point(C_MAX, C_MAX, C_MAX);
        send_point(C_MIN, C_MIN, C_MIN);
        send_point(C_MIN, C_MAX, C_MIN);
        send_point(C_MAX, C_MIN, C_MAX);
        send_point(-1, -1, -1);
    endtask

    // back-to-back stretch first, then random gaps with a full drain midway
    task automatic test_random_stream(input int count);
        for (int n = 0; n < count; n++) begin
            idle_pct = (n < 250) ? 0 : 32;
            if (n == count / 2)
                drain_backlog();
            send_point(random_coord(), random_coord(), random_coord());
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_coord_x    <= '0;
        i_coord_y    <= '0;
        i_coord_z    <= '0;
        mismatch_cnt = 0;
        cycle_cnt    = 0;
        ring_wr      = 0;
        ring_rd      = 0;
        idle_pct     = 32;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_origin_and_axes();
        test_negative_x();
        test_extremes();
        drain_backlog();
        test_random_stream(930);

        drain_backlog();
        repeat (LATENCY + 4) @(posedge i_clk);
        if (ring_wr != ring_rd)
            mismatch_cnt += ring_wr - ring_rd;
        if (mismatch_cnt == 0) begin
            $display("cartesian_to_spherical_tb: clean");
        end else begin
            $display("cartesian_to_spherical_tb: errors");
        end
        $finish;
    end

endmodule
